// ----- rtl/shift_or_exact_matcher_defines.svh -----
// Assertion macros shared by the matcher RTL.
// Clock and reset are taken from the names clk and rst in the using scope.
`ifndef SHIFT_OR_EXACT_MATCHER_DEFINES_SVH
`define SHIFT_OR_EXACT_MATCHER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define SOM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("som assertion failed");

// Next-cycle implication
`define SOM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("som assertion failed");

`else

`define SOM_ASSERT_IMP(label, ante, cons)
`define SOM_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- rtl/som_pkg.sv -----
`timescale 1ns / 1ps

package som_pkg;

  // Fixed field widths
  localparam int SYM_W   = 8;
  localparam int POS_W   = 32;
  localparam int ALPH_W  = 9;
  localparam logic [ALPH_W-1:0] ALPH_RESET = 9'd256;

  // Item operations
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYMBOL = 2'd1,
    ERR_LONG   = 2'd2,
    ERR_NOPAT  = 2'd3
  } err_t;

  // Control from the datapath to the symbol table
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } table_ctl_t;

endpackage

// ----- rtl/shift_or_exact_matcher.sv -----
`timescale 1ns / 1ps
`include "shift_or_exact_matcher_defines.svh"

// Shift-Or exact string matcher. Items stream in at one per cycle while the
// output is not stalled; each result passes through stage two and the output
// register. The accepting edge issues the read of the symbol's table word
// from a registered synchronous memory; when stage two advances, the match
// vector is updated or the modified table word written back, and the output
// register is loaded. A stalled output holds the item in stage two and drops
// in_ready. A new-pattern item clears the table at once through per-entry
// valid flags, so there is no clearing pass. Back-to-back accesses to the same
// table word are forwarded. The alphabet size register is always ready through
// the cfg channel; write it only while no item is in flight.
module shift_or_exact_matcher #(
  parameter int MAX_SYMBOLS = 256,
  parameter int MAX_PATTERN = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [som_pkg::ALPH_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [som_pkg::SYM_W-1:0]       symbol,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            match,
  output logic [som_pkg::POS_W-1:0]       start_position,
  output logic [1:0]                      error
);

  localparam int SYM_SPAN    = 2 ** som_pkg::SYM_W;
  localparam int TABLE_DEPTH = (MAX_SYMBOLS < SYM_SPAN) ? MAX_SYMBOLS : SYM_SPAN;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int LIM_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int POS_W       = som_pkg::POS_W;

  logic [som_pkg::ALPH_W-1:0] alphabet_size;
  logic                       s1_valid;
  logic [1:0]                 s1_op;
  logic [som_pkg::SYM_W-1:0]  s1_sym;
  logic                       s1_adv;
  logic                       accept;
  logic [LEN_W-1:0]           pattern_length;
  logic [LEN_W-1:0]           pattern_length_next;
  logic [MAX_PATTERN-1:0]     match_vector;
  logic [MAX_PATTERN-1:0]     match_vector_next;
  logic [MAX_PATTERN-1:0]     mv_shifted;
  logic [MAX_PATTERN-1:0]     mv_probe;
  logic [POS_W-1:0]           text_position;
  logic [POS_W-1:0]           text_position_next;
  logic [MAX_PATTERN-1:0]     entry;
  logic [MAX_PATTERN-1:0]     wr_data;
  logic                       sym_ok;
  logic                       res_match;
  logic [POS_W-1:0]           res_start;
  logic [1:0]                 res_error;
  som_pkg::table_ctl_t        tbl_ctl;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= som_pkg::ALPH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alphabet_size <= cfg_data;
    end
  end

  // Handshake: stage two drains into the output register
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // Advance the item into stage two
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= op;
      s1_sym <= symbol;
    end
  end

  // Symbol table
  som_table #(
    .DATA_W (MAX_PATTERN),
    .DEPTH  (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (tbl_ctl),
    .rd_addr (symbol[ADDR_W-1:0]),
    .wr_addr (s1_sym[ADDR_W-1:0]),
    .wr_data (wr_data),
    .entry   (entry)
  );

  // Symbol range check against the register and the table size
  assign sym_ok = ({1'b0, s1_sym} < alphabet_size) &&
                  (LIM_W'(s1_sym) < LIM_W'(MAX_SYMBOLS));

  assign mv_shifted = (match_vector << 1) | entry;
  assign mv_probe   = mv_shifted >> (pattern_length - LEN_W'(1));
  assign wr_data    = entry & ~(MAX_PATTERN'(1) << pattern_length);

  // Decode the item in stage two
  always_comb begin
    pattern_length_next = pattern_length;
    match_vector_next   = match_vector;
    text_position_next  = text_position;
    res_match           = 1'b0;
    res_start           = '0;
    res_error           = som_pkg::ERR_NONE;
    tbl_ctl.rd_en       = accept;
    tbl_ctl.wr_en       = 1'b0;
    tbl_ctl.clear       = 1'b0;
    unique case (s1_op)
      som_pkg::OP_START: begin
        pattern_length_next = '0;
        match_vector_next   = '1;
        text_position_next  = '0;
        tbl_ctl.clear       = s1_adv;
      end
      som_pkg::OP_PATTERN: begin
        if (!sym_ok) begin
          res_error = som_pkg::ERR_SYMBOL;
        end else if (pattern_length >= LEN_W'(MAX_PATTERN)) begin
          res_error = som_pkg::ERR_LONG;
        end else begin
          pattern_length_next = pattern_length + LEN_W'(1);
          tbl_ctl.wr_en       = s1_adv;
        end
      end
      som_pkg::OP_TEXT: begin
        if (!sym_ok) begin
          res_error = som_pkg::ERR_SYMBOL;
        end else if (pattern_length == '0) begin
          res_error = som_pkg::ERR_NOPAT;
        end else begin
          match_vector_next  = mv_shifted;
          text_position_next = text_position + POS_W'(1);
          if (!mv_probe[0]) begin
            res_match = 1'b1;
            res_start = text_position - POS_W'(pattern_length) + POS_W'(1);
          end
        end
      end
      default: begin
        res_error = som_pkg::ERR_NONE;
      end
    endcase
  end

  // Update the matcher state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      match_vector   <= '1;
      text_position  <= '0;
    end else if (s1_adv) begin
      pattern_length <= pattern_length_next;
      match_vector   <= match_vector_next;
      text_position  <= text_position_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      match          <= res_match;
      start_position <= res_start;
      error          <= res_error;
    end
  end

  `SOM_ASSERT_IMP(a_match_no_error, out_valid && match, error == som_pkg::ERR_NONE)
  `SOM_ASSERT_IMP(a_length_bound, 1'b1, pattern_length <= LEN_W'(MAX_PATTERN))
  `SOM_ASSERT_NXT(a_start_clears, s1_adv && (s1_op == som_pkg::OP_START),
                  (pattern_length == '0) && (text_position == '0))
  `SOM_ASSERT_NXT(a_stall_holds_stage, s1_valid && !s1_adv,
                  s1_valid && $stable(s1_op) && $stable(s1_sym))

endmodule

// ----- rtl/som_ram.sv -----
`timescale 1ns / 1ps

module som_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/som_table.sv -----
`timescale 1ns / 1ps
`include "shift_or_exact_matcher_defines.svh"

module som_table #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  som_pkg::table_ctl_t      ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic [DATA_W-1:0]        entry
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [DEPTH-1:0]  entry_valid;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [DATA_W-1:0] fwd_data;

  som_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Hold the address of the outstanding read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  // Track written entries; a new pattern drops them all at once
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      entry_valid <= '0;
    end else if (ctl.wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Keep the latest write for reads that overlap it
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      fwd_valid <= 1'b0;
    end else if (ctl.wr_en) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  // Select forwarded data, stored data, or the all-ones default
  always_comb begin
    if (fwd_valid && (fwd_addr == rd_addr_q)) begin
      entry = fwd_data;
    end else if (entry_valid[rd_addr_q]) begin
      entry = rdata;
    end else begin
      entry = '1;
    end
  end

  `SOM_ASSERT_IMP(a_no_write_on_clear, ctl.clear, !ctl.wr_en)
  `SOM_ASSERT_NXT(a_clear_drops_all, ctl.clear, (entry_valid == '0) && !fwd_valid)
  `SOM_ASSERT_NXT(a_write_marks_valid, ctl.wr_en, entry_valid[fwd_addr] && fwd_valid)

endmodule

// ----- tb/shift_or_exact_matcher_checker.sv -----
`timescale 1ns / 1ps

// Watch the matcher's channels, predict each result and compare it.
module shift_or_exact_matcher_checker #(
  parameter int MAX_SYMBOLS = 256,
  parameter int MAX_PATTERN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [som_pkg::ALPH_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic [som_pkg::SYM_W-1:0]  symbol,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       match,
  input  logic [som_pkg::POS_W-1:0]  start_position,
  input  logic [1:0]                 error,
  output int                         fail_count,
  output int                         pending,
  output int                         item_count,
  output int                         match_count,
  output int                         reject_count
);

  localparam int POS_W = som_pkg::POS_W;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
    som_pkg::err_t    err;
  } scan_result_t;

  // Predicted matcher state
  logic [63:0]                sym_mask [MAX_SYMBOLS];
  logic [63:0]                state_vec;
  logic [6:0]                 pat_len;
  logic [POS_W-1:0]           text_pos;
  logic [som_pkg::ALPH_W-1:0] alph_size;
  scan_result_t               awaited_results [$];

  // Refill the symbol table and restart the search
  function automatic void clear_pattern_state();
    for (int i = 0; i < MAX_SYMBOLS; i++) sym_mask[i] = '1;
    state_vec = '1;
    pat_len   = '0;
    text_pos  = '0;
  endfunction

  // Apply one item to the predicted state and return its result
  function automatic scan_result_t advance_matcher(logic [1:0] opc,
                                                   logic [som_pkg::SYM_W-1:0] sym);
    scan_result_t r;
    logic         sym_ok;
    r      = '0;
    sym_ok = (int'(sym) < int'(alph_size)) && (int'(sym) < MAX_SYMBOLS);
    unique case (opc)
      som_pkg::OP_START: clear_pattern_state();
      som_pkg::OP_PATTERN: begin
        if (!sym_ok) begin
          r.err = som_pkg::ERR_SYMBOL;
        end else if (int'(pat_len) >= MAX_PATTERN) begin
          r.err = som_pkg::ERR_LONG;
        end else begin
          sym_mask[sym][pat_len[5:0]] = 1'b0;
          pat_len = pat_len + 7'd1;
        end
      end
      som_pkg::OP_TEXT: begin
        if (!sym_ok) begin
          r.err = som_pkg::ERR_SYMBOL;
        end else if (pat_len == '0) begin
          r.err = som_pkg::ERR_NOPAT;
        end else begin
          state_vec = (state_vec << 1) | sym_mask[sym];
          if (!state_vec[pat_len - 7'd1]) begin
            r.hit   = 1'b1;
            r.start = text_pos - POS_W'(pat_len) + POS_W'(1);
          end
          text_pos = text_pos + POS_W'(1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Compare results first, then queue the prediction for a new item
  always @(posedge clk) begin
    scan_result_t want;
    int           bad;
    bad = 0;
    if (rst) begin
      clear_pattern_state();
      alph_size = som_pkg::ALPH_RESET;
      awaited_results.delete();
      fail_count   <= 0;
      pending      <= 0;
      item_count   <= 0;
      match_count  <= 0;
      reject_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) alph_size = cfg_data;
      if (out_valid && out_ready) begin
        match_count <= match_count + int'(match);
        if (error != som_pkg::ERR_NONE) reject_count <= reject_count + 1;
        if (awaited_results.size() == 0) begin
          $error("result with no item waiting: match %0d start_position %0d error %0d",
                 match, start_position, error);
          bad = 1;
        end else begin
          want = awaited_results.pop_front();
          if (match !== want.hit) begin
            $error("match: expected %0d, got %0d", want.hit, match);
            bad++;
          end
          if (start_position !== want.start) begin
            $error("start_position: expected %0d, got %0d", want.start, start_position);
            bad++;
          end
          if (error !== want.err) begin
            $error("error: expected %0d, got %0d", want.err, error);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.insert(awaited_results.size(), advance_matcher(op, symbol));
        item_count <= item_count + 1;
      end
      fail_count <= fail_count + bad;
      pending    <= awaited_results.size();
    end
  end

endmodule

// ----- tb/shift_or_exact_matcher_tb.sv -----
`timescale 1ns / 1ps

module shift_or_exact_matcher_tb;

  localparam int MAX_SYMBOLS    = 256;
  localparam int MAX_PATTERN    = 64;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SYM_W          = som_pkg::SYM_W;
  localparam int ALPH_W         = som_pkg::ALPH_W;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [ALPH_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                op;
  logic [SYM_W-1:0]          symbol;
  logic                      out_valid;
  logic                      out_ready;
  logic                      match;
  logic [som_pkg::POS_W-1:0] start_position;
  logic [1:0]                error;

  int fail_count;
  int pending;
  int item_count;
  int match_count;
  int reject_count;
  int items_sent;
  int alph_writes;
  int idle_cycles;
  bit no_stall;

  shift_or_exact_matcher dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .symbol         (symbol),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match          (match),
    .start_position (start_position),
    .error          (error)
  );

  shift_or_exact_matcher_checker #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .MAX_PATTERN (MAX_PATTERN)
  ) match_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Drive one item and hold it until accepted
  task automatic send_item(input logic [1:0] o, input logic [SYM_W-1:0] s);
    int gap;
    gap = no_stall ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    symbol   <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_alphabet(input int v);
    cfg_valid <= 1'b1;
    cfg_data  <= ALPH_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alph_writes++;
  endtask

  // Load a pattern over a small sub-alphabet, then feed text rich in copies of it
  task automatic play_search(input int eff, input int want_len);
    logic [SYM_W-1:0] pat [MAX_PATTERN];
    int len, k, base, tlen, i, j, r;
    k    = $urandom_range(1, (eff < 4) ? eff : 4);
    base = $urandom_range(0, eff - k);
    r    = $urandom_range(0, 31);
    if (want_len != 0) len = want_len;
    else if (r == 0) len = MAX_PATTERN;
    else if (r < 3) len = $urandom_range(7, MAX_PATTERN - 1);
    else len = $urandom_range(1, 6);
    send_item(som_pkg::OP_START, SYM_W'($urandom));
    for (j = 0; j < len; j++) begin
      pat[j] = SYM_W'(base + $urandom_range(0, k - 1));
      send_item(som_pkg::OP_PATTERN, pat[j]);
    end
    // one symbol past the pattern limit
    if (len == MAX_PATTERN) send_item(som_pkg::OP_PATTERN, SYM_W'(base));
    tlen = len + $urandom_range(0, (len < 8) ? 2 * len + 8 : len);
    i = 0;
    while (i < tlen) begin
      r = $urandom_range(0, 15);
      if (r < 6) begin
        for (j = 0; j < len; j++) send_item(som_pkg::OP_TEXT, pat[j]);
        i += len;
      end else if (r == 6) begin
        send_item(2'($urandom_range(1, 3)), SYM_W'($urandom));
        i++;
      end else begin
        send_item(som_pkg::OP_TEXT, SYM_W'(base + $urandom_range(0, k - 1)));
        i++;
      end
    end
  endtask

  task automatic run_phase(input int v, input int budget, input bit long_first);
    int eff, target, r;
    settle();
    write_alphabet(v);
    eff    = (v > MAX_SYMBOLS) ? MAX_SYMBOLS : v;
    target = items_sent + budget;
    if (long_first) play_search(eff, MAX_PATTERN);
    while (items_sent < target) begin
      no_stall = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (eff == 0 || r == 9) begin
        repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), SYM_W'($urandom));
      end else if (r == 8) begin
        send_item(som_pkg::OP_START, SYM_W'($urandom));
        send_item(som_pkg::OP_TEXT, SYM_W'($urandom_range(0, eff - 1)));
      end else begin
        play_search(eff, 0);
      end
    end
    no_stall = 1'b0;
  endtask

  // Result side: random stalls, or none while no_stall is set
  initial begin
    int hold;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (no_stall) begin
        out_ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        hold = pick_gap();
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(1, 15);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("shift_or_exact_matcher_tb failed");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    op          = som_pkg::OP_START;
    symbol      = '0;
    no_stall    = 1'b0;
    items_sent  = 0;
    alph_writes = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset alphabet: text before any pattern, unused op, one-symbol pattern
    send_item(som_pkg::OP_TEXT, 8'd255);
    send_item(OP_UNUSED, 8'd255);
    send_item(som_pkg::OP_PATTERN, 8'd255);
    send_item(som_pkg::OP_TEXT, 8'd255);
    settle();
    write_alphabet(4);

    // Small alphabet: out-of-range symbols, overlapping matches, pattern grown after text
    send_item(som_pkg::OP_START, 8'd255);
    send_item(som_pkg::OP_PATTERN, 8'd4);
    send_item(som_pkg::OP_TEXT, 8'd200);
    send_item(som_pkg::OP_TEXT, 8'd3);
    send_item(som_pkg::OP_PATTERN, 8'd0);
    send_item(som_pkg::OP_PATTERN, 8'd1);
    send_item(som_pkg::OP_PATTERN, 8'd0);
    send_item(som_pkg::OP_TEXT, 8'd0);
    send_item(som_pkg::OP_TEXT, 8'd1);
    send_item(som_pkg::OP_TEXT, 8'd0);
    send_item(som_pkg::OP_TEXT, 8'd1);
    send_item(som_pkg::OP_TEXT, 8'd0);
    send_item(som_pkg::OP_PATTERN, 8'd3);
    send_item(som_pkg::OP_TEXT, 8'd3);
    send_item(som_pkg::OP_TEXT, 8'd1);
    send_item(som_pkg::OP_TEXT, 8'd0);
    send_item(som_pkg::OP_TEXT, 8'd3);
    send_item(som_pkg::OP_START, 8'd0);
    send_item(som_pkg::OP_TEXT, 8'd0);

    run_phase(256, 60, 1'b1);
    run_phase(2, 30, 1'b0);
    run_phase(1, 25, 1'b0);
    run_phase(511, 30, 1'b0);
    run_phase(0, 15, 1'b0);
    run_phase(257, 25, 1'b0);
    run_phase($urandom_range(3, 255), 30, 1'b0);
    run_phase(256, 30, 1'b0);
    settle();

    $display("Ran %0d items under %0d alphabet settings, patterns up to %0d symbols.",
             item_count, alph_writes, MAX_PATTERN);
    $display("Results held %0d matches and %0d rejected items.", match_count, reject_count);
    if (fail_count == 0)
      $display("shift_or_exact_matcher_tb passed");
    else
      $display("shift_or_exact_matcher_tb failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/som_pkg.sv
rtl/som_ram.sv
rtl/som_table.sv
rtl/shift_or_exact_matcher.sv
tb/shift_or_exact_matcher_checker.sv
tb/shift_or_exact_matcher_tb.sv
